@@ rtl/lbba_pkg.sv @@
// lbba_pkg: shared widths, table entry layout and write port struct
// for the label bounding box accumulator
// no dependencies
package lbba_pkg;

    localparam int LABEL_BITS  = 16;
    localparam int COORD_BITS  = 12;
    localparam int TABLE_DEPTH = 1 << LABEL_BITS;

    typedef logic [LABEL_BITS-1:0] label_t;
    typedef logic [COORD_BITS-1:0] coord_t;

    // one table word: seen flag plus both corners
    typedef struct packed {
        logic   seen;
        coord_t lo_x;
        coord_t lo_y;
        coord_t lo_z;
        coord_t hi_x;
        coord_t hi_y;
        coord_t hi_z;
    } box_entry_t;

    typedef struct packed {
        logic       en;
        label_t     addr;
        box_entry_t data;
    } tbl_write_t;

endpackage

@@ rtl/lbba_table.sv @@
// lbba_table: label-indexed box table, one write port and one read port,
// read data registered
// depends on lbba_pkg
module lbba_table (
    input  logic                clk,
    input  lbba_pkg::tbl_write_t wr,
    input  logic                rd_en,
    input  lbba_pkg::label_t    rd_addr,
    output lbba_pkg::box_entry_t rd_data
);
    import lbba_pkg::*;

    box_entry_t mem [TABLE_DEPTH];
    box_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/lbba_clear.sv @@
// lbba_clear: walks the table once after reset and zeroes every entry
// depends on lbba_pkg
module lbba_clear (
    input  logic                 clk,
    input  logic                 rst_n,
    output logic                 clearing,
    output lbba_pkg::tbl_write_t wr
);
    import lbba_pkg::*;

    logic   clearing_reg, clearing_next;
    label_t addr_reg, addr_next;

    always_comb
    begin
        clearing_next = clearing_reg;
        addr_next     = addr_reg;
        if (clearing_reg)
        begin
            addr_next = addr_reg + label_t'(1);
            if (&addr_reg)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            addr_reg     <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            addr_reg     <= addr_next;
        end
    end

    assign clearing = clearing_reg;
    assign wr.en    = clearing_reg;
    assign wr.addr  = addr_reg;
    assign wr.data  = '0;

endmodule

@@ rtl/lbba_update.sv @@
// lbba_update: merges one point into a stored box entry
// depends on lbba_pkg
module lbba_update (
    input  lbba_pkg::box_entry_t old_entry,
    input  lbba_pkg::coord_t     px,
    input  lbba_pkg::coord_t     py,
    input  lbba_pkg::coord_t     pz,
    output lbba_pkg::box_entry_t new_entry,
    output logic                 first
);
    import lbba_pkg::*;

    always_comb
    begin
        first          = !old_entry.seen;
        new_entry.seen = 1'b1;
        if (first)
        begin
            new_entry.lo_x = px;
            new_entry.lo_y = py;
            new_entry.lo_z = pz;
            new_entry.hi_x = px;
            new_entry.hi_y = py;
            new_entry.hi_z = pz;
        end
        else
        begin
            new_entry.lo_x = (px < old_entry.lo_x) ? px : old_entry.lo_x;
            new_entry.lo_y = (py < old_entry.lo_y) ? py : old_entry.lo_y;
            new_entry.lo_z = (pz < old_entry.lo_z) ? pz : old_entry.lo_z;
            new_entry.hi_x = (px > old_entry.hi_x) ? px : old_entry.hi_x;
            new_entry.hi_y = (py > old_entry.hi_y) ? py : old_entry.hi_y;
            new_entry.hi_z = (pz > old_entry.hi_z) ? pz : old_entry.hi_z;
        end
    end

endmodule

@@ rtl/label_bounding_box_accumulator.sv @@
// label_bounding_box_accumulator: per-label bounding box table, top level
// depends on lbba_pkg, lbba_table, lbba_clear, lbba_update
//
//   channel   handshake          payload
//   request   start / busy       voxel_label, pos_x, pos_y, pos_z
//   result    done (one cycle)   first_seen, box_min_x/y/z, box_max_x/y/z
//
// one request per cycle while busy is low; its result strobes on done after
// the table read, then merge and write back; throughput set by the single
// read-modify-write per request, with the last write forwarded to the next read
// after reset the table's 2^LABEL_BITS entries are cleared one entry a cycle:
// busy stays high until the last entry is written, then stays low
// the receiver cannot stall, so no request is ever held off after clearing
module label_bounding_box_accumulator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  lbba_pkg::label_t   voxel_label,
    input  lbba_pkg::coord_t   pos_x,
    input  lbba_pkg::coord_t   pos_y,
    input  lbba_pkg::coord_t   pos_z,
    output logic               done,
    output logic               first_seen,
    output lbba_pkg::coord_t   box_min_x,
    output lbba_pkg::coord_t   box_min_y,
    output lbba_pkg::coord_t   box_min_z,
    output lbba_pkg::coord_t   box_max_x,
    output lbba_pkg::coord_t   box_max_y,
    output lbba_pkg::coord_t   box_max_z
);
    import lbba_pkg::*;

    logic       clearing;
    logic       accept;
    tbl_write_t clr_wr;
    tbl_write_t tbl_wr;
    box_entry_t rd_data;
    box_entry_t old_entry;
    box_entry_t new_entry;
    logic       first;

    // merge stage
    logic       s1_valid_reg;
    label_t     s1_label_reg;
    coord_t     s1_px_reg, s1_py_reg, s1_pz_reg;

    // last write, forwarded to a following request on the same label
    logic       fwd_valid_reg;
    label_t     fwd_label_reg;
    box_entry_t fwd_data_reg;

    // result
    logic       done_reg;
    logic       first_reg;
    box_entry_t res_reg;

    assign accept = start && !clearing;
    assign busy   = clearing;

    lbba_clear u_clear (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .wr       (clr_wr)
    );

    always_comb
    begin
        if (clearing)
        begin
            tbl_wr = clr_wr;
        end
        else
        begin
            tbl_wr.en   = s1_valid_reg;
            tbl_wr.addr = s1_label_reg;
            tbl_wr.data = new_entry;
        end
    end

    lbba_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_en   (accept),
        .rd_addr (voxel_label),
        .rd_data (rd_data)
    );

    assign old_entry = (fwd_valid_reg && fwd_label_reg == s1_label_reg) ? fwd_data_reg
                                                                        : rd_data;

    lbba_update u_update (
        .old_entry (old_entry),
        .px        (s1_px_reg),
        .py        (s1_py_reg),
        .pz        (s1_pz_reg),
        .new_entry (new_entry),
        .first     (first)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= s1_valid_reg;
            done_reg      <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_label_reg <= voxel_label;
            s1_px_reg    <= pos_x;
            s1_py_reg    <= pos_y;
            s1_pz_reg    <= pos_z;
        end
        if (s1_valid_reg)
        begin
            fwd_label_reg <= s1_label_reg;
            fwd_data_reg  <= new_entry;
            first_reg     <= first;
            res_reg       <= new_entry;
        end
    end

    assign done       = done_reg;
    assign first_seen = first_reg;
    assign box_min_x  = res_reg.lo_x;
    assign box_min_y  = res_reg.lo_y;
    assign box_min_z  = res_reg.lo_z;
    assign box_max_x  = res_reg.hi_x;
    assign box_max_y  = res_reg.hi_y;
    assign box_max_z  = res_reg.hi_z;

endmodule

@@ rtl/lbba_checker.sv @@
// lbba_checker: port-level assertions for the bounding box accumulator,
// bound to the top level
// depends on lbba_pkg and label_bounding_box_accumulator
module lbba_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic             first_seen,
    input lbba_pkg::coord_t box_min_x,
    input lbba_pkg::coord_t box_min_y,
    input lbba_pkg::coord_t box_min_z,
    input lbba_pkg::coord_t box_max_x,
    input lbba_pkg::coord_t box_max_y,
    input lbba_pkg::coord_t box_max_z
);
    import lbba_pkg::*;

    // every request taken while not busy gives its result on done
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("request without result");

    // no result without a request
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without request");

    // busy only during the clearing pass after reset
    a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose after clearing");

    // a first sighting gives a single-point box
    a_first_point: assert property (@(posedge clk) disable iff (!rst_n)
        (done && first_seen) |->
            (box_min_x == box_max_x && box_min_y == box_max_y && box_min_z == box_max_z))
        else $error("first sighting box not a point");

    // corners stay ordered
    a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (box_min_x <= box_max_x && box_min_y <= box_max_y && box_min_z <= box_max_z))
        else $error("box corners out of order");

endmodule

bind label_bounding_box_accumulator lbba_checker u_lbba_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .first_seen (first_seen),
    .box_min_x  (box_min_x),
    .box_min_y  (box_min_y),
    .box_min_z  (box_min_z),
    .box_max_x  (box_max_x),
    .box_max_y  (box_max_y),
    .box_max_z  (box_max_z)
);
